/* rtl/ivt_pkg.sv */
package ivt_pkg;

    // Result classes.
    localparam logic [1:0] VERDICT_FOREIGN   = 2'd0;
    localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
    localparam logic [1:0] VERDICT_VALID     = 2'd2;

    // Saturation limits and length bounds.
    localparam logic [4:0] CHAR_CAP    = 5'd31;
    localparam logic [2:0] DOT_CAP     = 3'd7;
    localparam logic [1:0] DIGIT_CAP   = 2'd3;
    localparam logic [8:0] OCTET_CAP   = 9'd256;
    localparam logic [8:0] OCTET_MAX   = 9'd255;
    localparam logic [4:0] LEN_MIN     = 5'd7;
    localparam logic [4:0] LEN_MAX     = 5'd15;
    localparam logic [2:0] DOTS_NEEDED = 3'd3;

    // ASCII codes used by the scanner.
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    // One character transfer.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in;

    // One result transfer.
    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] address;
        logic        special;
    } t_out;

    // Running scan state.
    typedef struct packed {
        logic [4:0]  char_count;
        logic [2:0]  dots_seen;
        logic        seen_digit;
        logic        seen_dot;
        logic        foreign_char;
        logic        previous_was_dot;
        logic        structure_error;
        logic [8:0]  octet_value;
        logic [1:0]  octet_digit_count;
        logic        octet_leading_zero;
        logic [23:0] prior_octets;
    } t_scan;

    // Loopback, private, multicast and link-local ranges.
    function automatic logic special_range(input logic [31:0] a);
        logic hit;
        hit = 1'b0;
        if ((a & 32'hFF000000) == 32'h7F000000) hit = 1'b1;
        if ((a & 32'hFF000000) == 32'h0A000000) hit = 1'b1;
        if ((a & 32'hFFF00000) == 32'hAC100000) hit = 1'b1;
        if ((a & 32'hFFFF0000) == 32'hC0A80000) hit = 1'b1;
        if ((a & 32'hF0000000) == 32'hE0000000) hit = 1'b1;
        if ((a & 32'hFFFF0000) == 32'hA9FE0000) hit = 1'b1;
        return hit;
    endfunction

endpackage

/* rtl/ivt_scan.sv */
module ivt_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  ivt_pkg::t_in  i_in,
    output ivt_pkg::t_out o_result
);

    ivt_pkg::t_scan r_scan;
    ivt_pkg::t_scan n_scan;

    logic        is_digit;
    logic        is_dot;
    logic [3:0]  digit;
    logic [11:0] octet_next;
    logic        final_error;
    logic [31:0] address;

    // Classify the character.
    assign is_digit = (i_in.character >= ivt_pkg::CHAR_ZERO) &&
                      (i_in.character <= ivt_pkg::CHAR_NINE);
    assign is_dot   = (i_in.character == ivt_pkg::CHAR_DOT);
    assign digit    = i_in.character[3:0];

    // Octet accumulator before saturation.
    assign octet_next = 12'(r_scan.octet_value) * 12'd10 + {8'd0, digit};

    // Next scan state after this character.
    always_comb begin
        n_scan = r_scan;
        if (is_digit) begin
            n_scan.seen_digit = 1'b1;
            if (r_scan.octet_digit_count == 2'd0) begin
                n_scan.octet_leading_zero = (digit == 4'd0);
            end else if (r_scan.octet_leading_zero) begin
                n_scan.structure_error = 1'b1;
            end
            if (r_scan.octet_value < ivt_pkg::OCTET_CAP) begin
                n_scan.octet_value = (octet_next > 12'(ivt_pkg::OCTET_CAP)) ?
                                     ivt_pkg::OCTET_CAP : octet_next[8:0];
            end
            if (r_scan.octet_digit_count < ivt_pkg::DIGIT_CAP) begin
                n_scan.octet_digit_count = r_scan.octet_digit_count + 2'd1;
            end
            n_scan.previous_was_dot = 1'b0;
        end else if (is_dot) begin
            n_scan.seen_dot = 1'b1;
            if ((r_scan.char_count == 5'd0) || r_scan.previous_was_dot ||
                (r_scan.octet_value > ivt_pkg::OCTET_MAX)) begin
                n_scan.structure_error = 1'b1;
            end
            n_scan.prior_octets       = {r_scan.prior_octets[15:0], r_scan.octet_value[7:0]};
            n_scan.octet_value        = 9'd0;
            n_scan.octet_digit_count  = 2'd0;
            n_scan.octet_leading_zero = 1'b0;
            if (r_scan.dots_seen < ivt_pkg::DOT_CAP) begin
                n_scan.dots_seen = r_scan.dots_seen + 3'd1;
            end
            n_scan.previous_was_dot = 1'b1;
        end else begin
            n_scan.foreign_char     = 1'b1;
            n_scan.previous_was_dot = 1'b0;
        end
        if (r_scan.char_count < ivt_pkg::CHAR_CAP) begin
            n_scan.char_count = r_scan.char_count + 5'd1;
        end
    end

    // Final checks on the last character: earlier structure errors, a trailing dot or a final octet above 255.
    assign final_error = n_scan.structure_error | is_dot |
                         (n_scan.octet_value > ivt_pkg::OCTET_MAX);
    assign address     = {n_scan.prior_octets, n_scan.octet_value[7:0]};

    // Classification of the whole string.
    always_comb begin
        o_result = '0;
        if (n_scan.foreign_char || !n_scan.seen_digit || !n_scan.seen_dot) begin
            o_result.verdict = ivt_pkg::VERDICT_FOREIGN;
        end else if ((n_scan.char_count < ivt_pkg::LEN_MIN) ||
                     (n_scan.char_count > ivt_pkg::LEN_MAX) ||
                     (n_scan.dots_seen != ivt_pkg::DOTS_NEEDED) || final_error) begin
            o_result.verdict = ivt_pkg::VERDICT_MALFORMED;
        end else begin
            o_result.verdict = ivt_pkg::VERDICT_VALID;
            o_result.address = address;
            o_result.special = ivt_pkg::special_range(address);
        end
    end

    // Scan state register; the last character returns it to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_accept) begin
            if (i_in.last) begin
                r_scan <= '0;
            end else begin
                r_scan <= n_scan;
            end
        end
    end

endmodule

/* rtl/ipv4_text_validator.sv */
// o_out_valid rises in the cycle after the transfer of the last character.
// Throughput: one character per cycle; a result is loaded while the previous
// one is being taken, so strings may follow each other without gaps.
// Only a last character waits while an untaken result is stalled.
// Synchronous active-low reset clears the scan state and the result valid flag.
module ipv4_text_validator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ivt_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ivt_pkg::t_out o_out
);

    logic          in_accept;
    logic          out_accept;
    ivt_pkg::t_out result;
    logic          r_out_valid;
    ivt_pkg::t_out r_out;

    // A last character needs room in the result register.
    assign o_in_stall = r_out_valid & i_out_stall & i_in.last;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign out_accept = r_out_valid & ~i_out_stall;

    ivt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_in     (i_in),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_in.last) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in.last) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // Every accepted last character produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.last) |=> o_out_valid)
        else $error("result missing after last character");

    // The verdict is always one of the defined classes.
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.verdict == ivt_pkg::VERDICT_FOREIGN) ||
                         (o_out.verdict == ivt_pkg::VERDICT_MALFORMED) ||
                         (o_out.verdict == ivt_pkg::VERDICT_VALID)))
        else $error("unused verdict code");

    // Address and special flag are zero unless the text is valid.
    a_zero_unless_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.verdict != ivt_pkg::VERDICT_VALID)) |->
        ((o_out.address == 32'd0) && !o_out.special))
        else $error("address given for invalid text");

    // A held result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !(in_accept && i_in.last))
        else $error("stalled result overwritten");
`endif

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned TARGET_CHARS = 1350;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned LONG_HOLD    = 120;
    localparam int unsigned SETTLE       = 20;

    typedef logic [7:0] t_text[$];

    // One character waiting to be offered, with its idle gap and an optional
    // pause until every outstanding verdict has been returned.
    typedef struct {
        ivt_pkg::t_in data;
        int unsigned  gap;
        bit           drain;
    } t_char_slot;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_out_stall = 1'b0;
    ivt_pkg::t_in  i_in        = '0;
    logic          o_in_stall;
    logic          o_out_valid;
    ivt_pkg::t_out o_out;

    ipv4_text_validator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    t_char_slot    char_slots[$];
    ivt_pkg::t_out verdicts_due[$];
    t_char_slot    offered;
    bit          slot_loaded   = 1'b0;
    int unsigned gap_left      = 0;
    bit          char_taken    = 1'b0;
    bit          pause_next    = 1'b0;
    int unsigned queued_chars  = 0;
    int unsigned strings_queued = 0;
    int unsigned cycle_count   = 0;
    int unsigned fail_count    = 0;

    // Scanner state of the predictor.
    logic [4:0]  n_chars;
    logic [2:0]  n_dots;
    bit          got_digit;
    bit          got_dot;
    bit          got_foreign;
    bit          after_dot;
    bit          bad_shape;
    logic [8:0]  octet_acc;
    logic [1:0]  octet_len;
    bit          octet_led_zero;
    logic [23:0] done_octets;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_scan();
        n_chars        = '0;
        n_dots         = '0;
        got_digit      = 1'b0;
        got_dot        = 1'b0;
        got_foreign    = 1'b0;
        after_dot      = 1'b0;
        bad_shape      = 1'b0;
        octet_acc      = '0;
        octet_len      = '0;
        octet_led_zero = 1'b0;
        done_octets    = '0;
    endfunction

    // Loopback, private, multicast and link-local blocks, by octet.
    function automatic logic reserved_block(input logic [31:0] a);
        return (a[31:24] == 8'd127) || (a[31:24] == 8'd10)
            || (a[31:24] == 8'd172 && a[23:20] == 4'h1)
            || (a[31:16] == 16'hC0A8) || (a[31:28] == 4'hE)
            || (a[31:16] == 16'hA9FE);
    endfunction

    // Advances the scanner by one character; returns 1 with the verdict when
    // the character closes the string.
    function automatic bit scan_char(input ivt_pkg::t_in c, output ivt_pkg::t_out res);
        logic [3:0]  d;
        int unsigned grown;
        bit          is_digit;
        bit          is_dot;
        logic [31:0] addr;
        is_digit = (c.character >= ivt_pkg::CHAR_ZERO) && (c.character <= ivt_pkg::CHAR_NINE);
        is_dot   = (c.character == ivt_pkg::CHAR_DOT);
        res      = '0;
        if (is_digit) begin
            d = c.character[3:0];
            got_digit = 1'b1;
            if (octet_len == 2'd0) begin
                octet_led_zero = (d == 4'd0);
            end else if (octet_led_zero) begin
                bad_shape = 1'b1;
            end
            if (octet_acc < ivt_pkg::OCTET_CAP) begin
                grown = octet_acc * 10 + d;
                octet_acc = (grown > ivt_pkg::OCTET_CAP) ? ivt_pkg::OCTET_CAP : grown[8:0];
            end
            if (octet_len != ivt_pkg::DIGIT_CAP) octet_len++;
            after_dot = 1'b0;
        end else if (is_dot) begin
            got_dot = 1'b1;
            if (n_chars == 5'd0 || after_dot || octet_acc > ivt_pkg::OCTET_MAX) bad_shape = 1'b1;
            done_octets    = {done_octets[15:0], octet_acc[7:0]};
            octet_acc      = '0;
            octet_len      = '0;
            octet_led_zero = 1'b0;
            if (n_dots != ivt_pkg::DOT_CAP) n_dots++;
            after_dot = 1'b1;
        end else begin
            got_foreign = 1'b1;
            after_dot   = 1'b0;
        end
        if (n_chars != ivt_pkg::CHAR_CAP) n_chars++;
        if (!c.last) return 1'b0;

        // A trailing dot, or a final octet out of range, spoils the shape.
        if (is_dot || octet_acc > ivt_pkg::OCTET_MAX) bad_shape = 1'b1;
        if (got_foreign || !got_digit || !got_dot) begin
            res.verdict = ivt_pkg::VERDICT_FOREIGN;
        end else if (n_chars < ivt_pkg::LEN_MIN || n_chars > ivt_pkg::LEN_MAX
                     || n_dots != ivt_pkg::DOTS_NEEDED || bad_shape) begin
            res.verdict = ivt_pkg::VERDICT_MALFORMED;
        end else begin
            addr        = {done_octets, octet_acc[7:0]};
            res.verdict = ivt_pkg::VERDICT_VALID;
            res.address = addr;
            res.special = reserved_block(addr);
        end
        clear_scan();
        return 1'b1;
    endfunction

    function automatic t_text text_bytes(input string s);
        t_text q;
        int    i;
        for (i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // Splits a string into character transfers with random gaps; roughly one
    // string in four goes out back to back.
    task automatic queue_string(input t_text s);
        t_char_slot  slot_new;
        bit          burst;
        int unsigned r;
        int          i;
        burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < s.size(); i++) begin
            r = $urandom_range(0, 99);
            slot_new.data.character = s[i];
            slot_new.data.last      = (i == s.size() - 1);
            if (burst || r < 55) slot_new.gap = 0;
            else if (r < 85) slot_new.gap = $urandom_range(1, 3);
            else if (r < 97) slot_new.gap = $urandom_range(4, 12);
            else slot_new.gap = $urandom_range(20, 60);
            slot_new.drain = (i == 0) && pause_next;
            char_slots.push_back(slot_new);
        end
        pause_next = 1'b0;
        queued_chars += s.size();
        strings_queued++;
        if (strings_queued % 37 == 0) pause_next = 1'b1;
    endtask

    // A dotted quad with random content, often in a special range, and
    // sometimes damaged in one place.
    task automatic queue_random_address();
        t_text       s;
        int          o[4];
        int          k;
        int          i;
        int          n;
        int          p;
        logic [7:0]  b;
        int unsigned r;
        for (k = 0; k < 4; k++) begin
            r = $urandom_range(0, 3);
            o[k] = (r == 0) ? $urandom_range(0, 9)
                 : (r == 1) ? $urandom_range(10, 99) : $urandom_range(100, 255);
        end
        case ($urandom_range(0, 7))
            0: o[0] = 127;
            1: o[0] = 10;
            2: begin
                o[0] = 172;
                o[1] = $urandom_range(14, 33);
            end
            3: begin
                o[0] = 192;
                if ($urandom_range(0, 1) == 1) o[1] = 168;
            end
            4: begin
                o[0] = 169;
                if ($urandom_range(0, 1) == 1) o[1] = 254;
            end
            5: o[0] = $urandom_range(223, 240);
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0) o[$urandom_range(0, 3)] = $urandom_range(256, 1500);
        for (k = 0; k < 4; k++) begin
            s = {s, text_bytes($sformatf("%0d", o[k]))};
            if (k < 3) s.push_back(ivt_pkg::CHAR_DOT);
        end
        case ($urandom_range(0, 9))
            5: begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= ivt_pkg::CHAR_ZERO && b <= ivt_pkg::CHAR_NINE)
                       || b == ivt_pkg::CHAR_DOT);
                s.insert($urandom_range(0, s.size()), b);
            end
            6: s.delete($urandom_range(0, s.size() - 1));
            7: s.insert($urandom_range(0, s.size()), ivt_pkg::CHAR_DOT);
            8: begin
                // Leading zero at the start of one octet.
                k = $urandom_range(0, 3);
                p = 0;
                n = 0;
                for (i = 0; i < s.size() && n < k; i++) begin
                    if (s[i] == ivt_pkg::CHAR_DOT) begin
                        n++;
                        p = i + 1;
                    end
                end
                s.insert(p, ivt_pkg::CHAR_ZERO);
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: s = {s, text_bytes($sformatf(".%0d", $urandom_range(0, 255)))};
                    1: s.push_front(ivt_pkg::CHAR_DOT);
                    default: s.push_back(ivt_pkg::CHAR_DOT);
                endcase
            end
            default: ;
        endcase
        queue_string(s);
    endtask

    // Noise: digits, dots and arbitrary bytes in any order.
    task automatic queue_noise();
        t_text       s;
        int          len;
        int          i;
        int unsigned r;
        len = $urandom_range(1, 35);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) s.push_back(8'(ivt_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            else if (r < 70) s.push_back(ivt_pkg::CHAR_DOT);
            else s.push_back(8'($urandom_range(0, 255)));
        end
        queue_string(s);
    endtask

    // Sender: offers the next character at the falling edge once the current
    // transfer has completed, honouring gaps and pauses.
    always @(negedge i_clk) begin : feed_chars
        logic valid_next;
        if (i_rst_n && (!i_in_valid || char_taken)) begin
            valid_next = 1'b0;
            if (!slot_loaded && char_slots.size() != 0) begin
                offered     = char_slots.pop_front();
                slot_loaded = 1'b1;
                gap_left    = offered.gap;
            end
            if (slot_loaded && !(offered.drain && verdicts_due.size() != 0)) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    valid_next  = 1'b1;
                    i_in       <= offered.data;
                    slot_loaded = 1'b0;
                end
            end
            i_in_valid <= valid_next;
        end
    end

    // Receiver: alternating stretches of stalling and taking, with long
    // hold-offs that let the block back up into its input.
    always @(negedge i_clk) begin : pace_results
        static int unsigned hold_left  = 0;
        static int unsigned phase_left = 0;
        static bit          stalling   = 1'b0;
        logic        stall_next;
        if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (cycle_count == HOLD_AT
                     || (i_in_valid && $urandom_range(0, 2999) == 0)) begin
            hold_left  = LONG_HOLD;
            stall_next = 1'b1;
        end else begin
            if (phase_left == 0) begin
                stalling = !stalling;
                if (stalling) begin
                    phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
                end else begin
                    phase_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 12);
                end
            end
            phase_left--;
            stall_next = stalling;
        end
        i_out_stall <= stall_next;
    end

    // Monitor: checks each result transfer against the oldest expectation,
    // then predicts from the character accepted at this edge.
    always @(posedge i_clk) begin : watch_transfers
        ivt_pkg::t_out want;
        ivt_pkg::t_out seen;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            char_taken = i_rst_n && i_in_valid && !o_in_stall;
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                seen = o_out;
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result: verdict %0d address %h special %0d",
                           seen.verdict, seen.address, seen.special);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (seen.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, seen.verdict);
                        fail_count++;
                    end
                    if (seen.address !== want.address) begin
                        $error("address: expected %h, got %h", want.address, seen.address);
                        fail_count++;
                    end
                    if (seen.special !== want.special) begin
                        $error("special: expected %0d, got %0d", want.special, seen.special);
                        fail_count++;
                    end
                end
            end
            if (char_taken && scan_char(i_in, want)) verdicts_due.push_back(want);
        end
    end

    initial begin : run
        static string directed[] = '{
            "192.168.1.1", "0.0.0.0", "255.255.255.255", "127.0.0.1", "10.1.2.3",
            "172.16.0.1", "172.32.0.1", "169.254.9.9", "224.0.0.1", "8.8.8.8",
            "1.2.3", "1.2.3.4.5", ".1.2.34", "1.2.34.", "1..2.34", "256.1.1.1",
            "1.1.1.999", "01.1.1.1", "1.1.1.00", "1.1.1.1a", "1234", "...",
            "1.1.1.10000000000000000000000000000000", "1..........1", "7"
        };
        t_text s;
        clear_scan();

        // Directed strings, then foreign bytes at both ends of the code range.
        foreach (directed[i]) queue_string(text_bytes(directed[i]));
        s = text_bytes("1.1.1.1");
        s.insert(3, 8'h00);
        queue_string(s);
        s = text_bytes("9.9.9.9");
        s.push_back(8'hFF);
        queue_string(s);
        pause_next = 1'b1;

        // Random part: mostly dotted quads, the rest noise.
        while (queued_chars < TARGET_CHARS) begin
            if ($urandom_range(0, 99) < 80) queue_random_address();
            else queue_noise();
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (char_slots.size() != 0 || slot_loaded || i_in_valid);
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
